// File: design/sobel_pkg.sv
// Shared constants, types and the square-root step function of the Sobel magnitude block.
package sobel_pkg;

  // Default maximum line length held by the line stores.
  localparam int MAX_LINE_DEF = 2048;

  // Pixel and magnitude widths.
  localparam int PIX_W = 8;

  // Configuration register file: word-aligned, one register.
  localparam int CFG_AW = 3;
  localparam int CFG_W  = 32;
  localparam int LINE_WIDTH_W = 12;
  localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = 12'd1920;
  localparam logic [0:0] REG_LINE_WIDTH = 1'b0;

  // Saturated output value.
  localparam logic [PIX_W-1:0] MAG_SAT = 8'd255;

  // Partial state of the digit-by-digit square root.
  typedef struct packed {
    logic [9:0] rem;
    logic [7:0] root;
  } sqrt_t;

  // Four radix-4 steps of the restoring square root; consumes eight radicand bits.
  function automatic sqrt_t root_step4(sqrt_t acc, logic [7:0] bits);
    sqrt_t r;
    logic [10:0] rem;
    logic [10:0] trial;
    r = acc;
    for (int i = 3; i >= 0; i--) begin
      rem   = {r.rem[8:0], bits[2*i+1 -: 2]};
      trial = {1'b0, r.root, 2'b01};
      if (trial <= rem) begin
        r.rem  = 10'(rem - trial);
        r.root = {r.root[6:0], 1'b1};
      end else begin
        r.rem  = rem[9:0];
        r.root = {r.root[6:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

// File: design/sobel_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module sobel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // A read in the same cycle as a write to the same entry returns the old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/sobel_edge_magnitude.sv
// Sobel 3x3 gradient magnitude over a raster pixel stream, with two line-store RAMs.
//
// Pixels enter on the input channel (in_valid_i / in_stall_o) one transaction each, in
// raster order; frame_start_i marks the first pixel of a frame and restarts the window.
// Window rows lie line_width pixels apart in the flat stream, so the window wraps
// across line ends. From pixel 2W+2 of a frame on, every pixel yields one
// magnitude transaction on the output channel (out_valid_o / out_stall_i).
// Throughput is one pixel per clock while out_stall_i is low: each pixel makes one read
// and one write on each line store, with the write of one pixel forwarded to the read
// of the next when both fall on the same column. Results pass the stage 1 to 4 registers
// and the output register. When the receiver stalls, the result stages fill up behind the
// output register and in_stall_o rises only once every stage holds a result.
// Reset sets line_width to 1920 and clears the window, position count and column
// pointer. The line stores are not swept: a high-water mark of the columns written in
// the current frame makes unwritten columns read as zero, so no clearing pass is needed.
// Write line_width through the APB port only while idle; the block does not check.
module sobel_edge_magnitude #(
  parameter int MAX_LINE = sobel_pkg::MAX_LINE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Pixel input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [sobel_pkg::PIX_W-1:0]     pixel_i,
  input  logic                            frame_start_i,
  // Magnitude output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [sobel_pkg::PIX_W-1:0]     magnitude_o,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [sobel_pkg::CFG_AW-1:0]    paddr,
  input  logic [sobel_pkg::CFG_W-1:0]     pwdata,
  output logic [sobel_pkg::CFG_W-1:0]     prdata,
  output logic                            pready
);

  localparam int AW = $clog2(MAX_LINE);
  localparam int WW = $clog2(MAX_LINE + 1);
  localparam int PW = $clog2(2 * MAX_LINE + 2);
  localparam logic [PW-1:0] POS_CAP = PW'(2 * MAX_LINE + 1);
  localparam int PX = sobel_pkg::PIX_W;

  // ------------------------------------------------------------------
  // Configuration register
  // ------------------------------------------------------------------
  logic [sobel_pkg::LINE_WIDTH_W-1:0] line_width_q;
  logic                               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[2:2] == sobel_pkg::REG_LINE_WIDTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= sobel_pkg::LINE_WIDTH_RST;
    end else if (cfg_wr) begin
      line_width_q <= pwdata[sobel_pkg::LINE_WIDTH_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2:2] == sobel_pkg::REG_LINE_WIDTH) begin
      prdata = {{(sobel_pkg::CFG_W - sobel_pkg::LINE_WIDTH_W){1'b0}}, line_width_q};
    end
  end

  // Effective width, clamped to 1..MAX_LINE.
  logic [WW-1:0] w_eff;

  always_comb begin
    if (line_width_q == '0) begin
      w_eff = WW'(1);
    end else if (32'(line_width_q) > 32'(MAX_LINE)) begin
      w_eff = WW'(MAX_LINE);
    end else begin
      w_eff = WW'(line_width_q);
    end
  end

  // ------------------------------------------------------------------
  // Stage handshake
  // ------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, out_valid_q;
  logic s1_emit_q;
  logic out_ready, s4_ready, s3_ready, s2_ready, s1_ready, s1_go, accept;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s4_ready   = !s4_valid_q || out_ready;
  assign s3_ready   = !s3_valid_q || s4_ready;
  assign s2_ready   = !s2_valid_q || s3_ready;
  assign s1_go      = s1_valid_q && (!s1_emit_q || s2_ready);
  assign s1_ready   = !s1_valid_q || s1_go;
  assign accept     = in_valid_i && s1_ready;
  assign in_stall_o = !s1_ready;

  // ------------------------------------------------------------------
  // Acceptance: column pointer, high-water mark and position count
  // ------------------------------------------------------------------
  logic [AW-1:0] ptr_q, ptr_d;
  logic [WW-1:0] hw_q, hw_d;
  logic [PW-1:0] pos_q, pos_d;

  logic [AW-1:0] ptr_base, acc_ptr;
  logic [WW-1:0] hw_base, ptr_inc;
  logic [PW-1:0] pos_base;
  logic          acc_mid_valid, acc_emit, acc_fwd;

  logic [AW-1:0] s1_addr_q;

  always_comb begin
    ptr_base = frame_start_i ? '0 : ptr_q;
    hw_base  = frame_start_i ? '0 : hw_q;
    pos_base = frame_start_i ? '0 : pos_q;

    // A width change can leave the pointer beyond the line; it wraps to column zero.
    acc_ptr = (WW'(ptr_base) >= w_eff) ? '0 : ptr_base;
    ptr_inc = WW'(acc_ptr) + WW'(1);

    // Columns below the high-water mark were written in this frame.
    acc_mid_valid = WW'(acc_ptr) < hw_base;
    hw_d  = (ptr_inc > hw_base) ? ptr_inc : hw_base;
    ptr_d = (ptr_inc >= w_eff) ? '0 : AW'(ptr_inc);

    acc_emit = pos_base >= {w_eff, 1'b1};
    pos_d    = (pos_base < POS_CAP) ? pos_base + PW'(1) : pos_base;

    // The entry being written this cycle is the one read: take the write data instead.
    acc_fwd = s1_go && (s1_addr_q == acc_ptr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      hw_q  <= '0;
      pos_q <= '0;
    end else if (accept) begin
      ptr_q <= ptr_d;
      hw_q  <= hw_d;
      pos_q <= pos_d;
    end
  end

  // ------------------------------------------------------------------
  // Line stores
  // ------------------------------------------------------------------
  logic [PX-1:0] mid_rdata, up_rdata;
  logic [PX-1:0] mid_in, top_in;
  logic [PX-1:0] s1_px_q;

  sobel_ram #(
    .WIDTH (PX),
    .DEPTH (MAX_LINE)
  ) u_mid_ram (
    .clk_i   (clk_i),
    .we_i    (s1_go),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_px_q),
    .re_i    (accept),
    .raddr_i (acc_ptr),
    .rdata_o (mid_rdata)
  );

  sobel_ram #(
    .WIDTH (PX),
    .DEPTH (MAX_LINE)
  ) u_up_ram (
    .clk_i   (clk_i),
    .we_i    (s1_go),
    .waddr_i (s1_addr_q),
    .wdata_i (mid_in),
    .re_i    (accept),
    .raddr_i (acc_ptr),
    .rdata_o (up_rdata)
  );

  // ------------------------------------------------------------------
  // Stage 1: read data, window update, gradients
  // ------------------------------------------------------------------
  logic          s1_fs_q, s1_mv_q, s1_fwd_q;
  logic [PX-1:0] fwd_mid_q, fwd_up_q;
  logic [PX-1:0] taps_q [9];
  logic [PX-1:0] taps_d [9];
  logic [PX-1:0] old_taps [9];
  logic signed [10:0] e [9];
  logic signed [10:0] gx, gy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q   <= pixel_i;
      s1_fs_q   <= frame_start_i;
      s1_addr_q <= acc_ptr;
      s1_mv_q   <= acc_mid_valid;
      s1_emit_q <= acc_emit;
      s1_fwd_q  <= acc_fwd;
    end
    if (s1_go) begin
      fwd_mid_q <= s1_px_q;
      fwd_up_q  <= mid_in;
    end
  end

  always_comb begin
    // Unwritten columns read as zero; both stores share the written prefix.
    mid_in = '0;
    top_in = '0;
    if (s1_mv_q) begin
      mid_in = s1_fwd_q ? fwd_mid_q : mid_rdata;
      top_in = s1_fwd_q ? fwd_up_q  : up_rdata;
    end

    for (int k = 0; k < 9; k++) begin
      old_taps[k] = s1_fs_q ? '0 : taps_q[k];
    end
    for (int r = 0; r < 3; r++) begin
      taps_d[r*3]   = old_taps[r*3+1];
      taps_d[r*3+1] = old_taps[r*3+2];
    end
    taps_d[2] = top_in;
    taps_d[5] = mid_in;
    taps_d[8] = s1_px_q;

    for (int k = 0; k < 9; k++) begin
      e[k] = $signed({3'b000, taps_d[k]});
    end
    gx = (e[2] - e[0]) + ((e[5] - e[3]) <<< 1) + (e[8] - e[6]);
    gy = (e[6] - e[0]) + ((e[7] - e[1]) <<< 1) + (e[8] - e[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        taps_q[k] <= '0;
      end
    end else if (s1_go) begin
      for (int k = 0; k < 9; k++) begin
        taps_q[k] <= taps_d[k];
      end
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: squares of the gradients
  // ------------------------------------------------------------------
  logic signed [10:0] gx_q, gy_q;
  logic signed [21:0] gx2, gy2;
  logic [20:0] sqx_q, sqy_q;

  assign gx2 = gx_q * gx_q;
  assign gy2 = gy_q * gy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_go && s1_emit_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_go && s1_emit_q) begin
      gx_q <= gx;
      gy_q <= gy;
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: sum, saturation check, upper four root digits
  // ------------------------------------------------------------------
  logic [21:0]      sum;
  logic             sat;
  sobel_pkg::sqrt_t hi_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      sqx_q <= gx2[20:0];
      sqy_q <= gy2[20:0];
    end
  end

  assign sum    = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign sat    = |sum[21:16];
  assign hi_acc = sobel_pkg::root_step4('0, sum[15:8]);

  // ------------------------------------------------------------------
  // Stage 4: lower four root digits and output register
  // ------------------------------------------------------------------
  sobel_pkg::sqrt_t s4_acc_q, lo_acc;
  logic [7:0]       s4_lo_q;
  logic             s4_sat_q;
  logic [PX-1:0]    mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (s4_ready) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s4_ready && s3_valid_q) begin
      s4_acc_q <= hi_acc;
      s4_lo_q  <= sum[7:0];
      s4_sat_q <= sat;
    end
  end

  assign lo_acc = sobel_pkg::root_step4(s4_acc_q, s4_lo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && s4_valid_q) begin
      mag_q <= s4_sat_q ? sobel_pkg::MAG_SAT : lo_acc.root;
    end
  end

  assign out_valid_o = out_valid_q;
  assign magnitude_o = mag_q;

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------

  // A frame start never sees line-store data from the previous frame.
  a_fs_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && frame_start_i |-> !acc_mid_valid)
    else $error("frame start read a stale line-store entry");

  // Forwarding is only chosen while the older transaction writes the stores.
  a_fwd_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && acc_fwd |-> s1_valid_q && s1_go)
    else $error("forwarding without a concurrent line-store write");

  // The high-water mark never exceeds the store depth.
  a_hw_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hw_q <= WW'(MAX_LINE))
    else $error("high-water mark beyond line-store depth");

  // The position count saturates at its cap.
  a_pos_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= POS_CAP)
    else $error("position count beyond its cap");

endmodule

// File: tb/sobel_edge_magnitude_tb.sv
// Self-checking testbench for the Sobel gradient magnitude block.
`timescale 1ns / 1ps

module sobel_edge_magnitude_tb;

  localparam int          MAX_LINE      = sobel_pkg::MAX_LINE_DEF;
  localparam int unsigned COUNT_CAP     = 2 * MAX_LINE + 1;
  localparam int          RANDOM_ITEMS  = 1000;
  localparam int          WIDE_ITEMS    = 200;
  localparam int          TAIL_ITEMS    = 150;
  localparam int          SETTLE_CYCLES = 12;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          PRINT_LIMIT   = 40;
  localparam logic [sobel_pkg::CFG_AW-1:0] LINE_WIDTH_ADDR =
    sobel_pkg::CFG_AW'({sobel_pkg::REG_LINE_WIDTH, 2'b00});

  // Hand-picked pixels: two frames at a line width of three.
  localparam int DIRECTED_COUNT = 25;
  localparam int SECOND_FRAME   = 16;
  localparam logic [sobel_pkg::PIX_W-1:0] DIRECTED_PIXELS [DIRECTED_COUNT] = '{
    8'd255, 8'd0, 8'd255, 8'd0, 8'd1, 8'd128, 8'd254,
    8'd77, 8'd77, 8'd77, 8'd77, 8'd77, 8'd77, 8'd77, 8'd77, 8'd77,
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255
  };

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           in_valid_i    = 1'b0;
  logic                           in_stall_o;
  logic [sobel_pkg::PIX_W-1:0]    pixel_i       = '0;
  logic                           frame_start_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i   = 1'b0;
  logic [sobel_pkg::PIX_W-1:0]    magnitude_o;
  logic                           psel          = 1'b0;
  logic                           penable       = 1'b0;
  logic                           pwrite        = 1'b0;
  logic [sobel_pkg::CFG_AW-1:0]   paddr         = '0;
  logic [sobel_pkg::CFG_W-1:0]    pwdata        = '0;
  logic [sobel_pkg::CFG_W-1:0]    prdata;
  logic                           pready;

  sobel_edge_magnitude u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pixel_i       (pixel_i),
    .frame_start_i (frame_start_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .magnitude_o   (magnitude_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Predictor state: a private copy of the line stores, window and counters.
  logic [sobel_pkg::LINE_WIDTH_W-1:0] cfg_line_width;
  logic [sobel_pkg::PIX_W-1:0]        upper_row [MAX_LINE];
  logic [sobel_pkg::PIX_W-1:0]        middle_row [MAX_LINE];
  logic [sobel_pkg::PIX_W-1:0]        window [9];
  int unsigned                        pixel_count;
  int unsigned                        column_ptr;

  logic [sobel_pkg::PIX_W-1:0] pending_magnitudes [$];
  logic [sobel_pkg::PIX_W-1:0] oldest_magnitude;
  int                          mismatch_count = 0;
  int                          cycle_count    = 0;
  bit                          idle_enable    = 1'b0;

  // Clock generation.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic void clear_frame_state();
    foreach (upper_row[i]) upper_row[i] = '0;
    foreach (middle_row[i]) middle_row[i] = '0;
    foreach (window[i]) window[i] = '0;
    pixel_count = 0;
    column_ptr  = 0;
  endfunction

  // Floor square root found bit by bit, saturated at the pixel maximum.
  function automatic logic [sobel_pkg::PIX_W-1:0] floor_root_sat(input int unsigned radicand);
    int unsigned root;
    int unsigned trial;
    if (radicand >= 32'd65536) return sobel_pkg::MAG_SAT;
    root = 0;
    for (int b = 7; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= radicand) root = trial;
    end
    return sobel_pkg::PIX_W'(root);
  endfunction

  // Advance the predictor by one pixel and queue the magnitude it produces, if any.
  function automatic void predict_magnitude(input logic [sobel_pkg::PIX_W-1:0] px,
                                            input logic fs);
    int unsigned                 w;
    int unsigned                 ptr;
    int unsigned                 q;
    logic [sobel_pkg::PIX_W-1:0] from_middle;
    logic [sobel_pkg::PIX_W-1:0] from_upper;
    int                          gx;
    int                          gy;
    w = cfg_line_width;
    if (w < 1) w = 1;
    if (w > MAX_LINE) w = MAX_LINE;
    if (fs) clear_frame_state();
    if (column_ptr >= w) column_ptr = 0;
    ptr = column_ptr;
    from_middle     = middle_row[ptr];
    from_upper      = upper_row[ptr];
    upper_row[ptr]  = from_middle;
    middle_row[ptr] = px;
    column_ptr = (ptr + 1 >= w) ? 0 : ptr + 1;
    for (int r = 0; r < 3; r++) begin
      window[r*3]   = window[r*3+1];
      window[r*3+1] = window[r*3+2];
    end
    window[2] = from_upper;
    window[5] = from_middle;
    window[8] = px;
    q = pixel_count;
    if (pixel_count < COUNT_CAP) pixel_count++;
    if (q < 2 * w + 1) return;
    gx = (int'(window[2]) - int'(window[0])) + 2 * (int'(window[5]) - int'(window[3]))
       + (int'(window[8]) - int'(window[6]));
    gy = (int'(window[6]) - int'(window[0])) + 2 * (int'(window[7]) - int'(window[1]))
       + (int'(window[8]) - int'(window[2]));
    pending_magnitudes.push_back(floor_root_sat(gx * gx + gy * gy));
  endfunction

  // Compare every magnitude transaction with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_magnitudes.size() == 0) begin
        report_mismatch($sformatf("magnitude %0d with no prediction pending", magnitude_o));
      end else begin
        oldest_magnitude = pending_magnitudes.pop_front();
        if (magnitude_o !== oldest_magnitude)
          report_mismatch($sformatf("magnitude %0d, predicted %0d",
                                    magnitude_o, oldest_magnitude));
      end
    end
  end

  // Receiver stalls come in random bursts while idling is enabled.
  initial begin
    forever begin
      @(posedge clk_i);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Send one pixel transaction, with an optional idle burst ahead of it.
  task automatic send_pixel(input logic [sobel_pkg::PIX_W-1:0] px, input logic fs);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    pixel_i       <= px;
    frame_start_i <= fs;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    predict_magnitude(px, fs);
  endtask

  task automatic hold_input();
    in_valid_i <= 1'b0;
  endtask

  // Wait until every predicted magnitude has been seen, then let the pipeline settle.
  task automatic wait_results_done();
    while (pending_magnitudes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [sobel_pkg::PIX_W-1:0] random_pixel();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return sobel_pkg::PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // One APB transfer: setup phase, access phase until pready, then psel and penable drop.
  task automatic apb_access(input logic wr, input logic [sobel_pkg::CFG_W-1:0] wdata,
                            output logic [sobel_pkg::CFG_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= LINE_WIDTH_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_line_width_readback();
    logic [sobel_pkg::CFG_W-1:0] rdata;
    apb_access(1'b0, '0, rdata);
    if (rdata[sobel_pkg::LINE_WIDTH_W-1:0] !== cfg_line_width)
      report_mismatch($sformatf("line_width reads %0d, written %0d",
                                rdata[sobel_pkg::LINE_WIDTH_W-1:0], cfg_line_width));
  endtask

  // Write line_width with random upper bits, which the register drops.
  task automatic write_line_width(input logic [sobel_pkg::LINE_WIDTH_W-1:0] w);
    logic [sobel_pkg::CFG_W-1:0] wdata;
    logic [sobel_pkg::CFG_W-1:0] rdata;
    wdata = $urandom;
    wdata[sobel_pkg::LINE_WIDTH_W-1:0] = w;
    apb_access(1'b1, wdata, rdata);
    cfg_line_width = w;
    check_line_width_readback();
  endtask

  // Register reset value and the extreme values of the field.
  task automatic test_register_access();
    check_line_width_readback();
    write_line_width('0);
    write_line_width('1);
    write_line_width(12'd2048);
    write_line_width(12'd1);
  endtask

  // Two short frames: saturation, a flat region and a restart of the frame.
  task automatic test_directed_frames();
    idle_enable = 1'b1;
    write_line_width(12'd3);
    for (int i = 0; i < DIRECTED_COUNT; i++)
      send_pixel(DIRECTED_PIXELS[i], i == 0 || i == SECOND_FRAME);
    hold_input();
    wait_results_done();
  endtask

  // Narrow the line while the column pointer sits past the new end.
  task automatic test_width_change_midstream();
    repeat (5) send_pixel(random_pixel(), 1'b0);
    hold_input();
    wait_results_done();
    write_line_width(12'd2);
    repeat (12) send_pixel(random_pixel(), 1'b0);
    hold_input();
    wait_results_done();
    write_line_width('0);
    repeat (10) send_pixel(random_pixel(), 1'b0);
    hold_input();
    wait_results_done();
  endtask

  // The sender stops mid-frame until every result is out, then goes on.
  task automatic test_pause_until_drained();
    write_line_width(12'd5);
    for (int i = 0; i < 20; i++) send_pixel(random_pixel(), i == 0);
    hold_input();
    wait_results_done();
    repeat (20) send_pixel(random_pixel(), 1'b0);
    hold_input();
    wait_results_done();
  endtask

  // Longest line, then an out-of-range width that clamps to the same length.
  // The frame stays in its warm-up, so no magnitude may appear.
  task automatic test_widest_line();
    idle_enable = ($urandom_range(0, 1) != 0);
    write_line_width(12'd2048);
    for (int i = 0; i < WIDE_ITEMS; i++) send_pixel(random_pixel(), i == 0);
    hold_input();
    wait_results_done();
    write_line_width(12'hFFF);
    repeat (60) send_pixel(random_pixel(), 1'b0);
    hold_input();
    wait_results_done();
  endtask

  // Random widths, mostly whole frames, with stray restarts and drained pauses.
  task automatic test_random_frames();
    int unsigned                        sent;
    int unsigned                        n;
    int unsigned                        w_eff;
    logic [sobel_pkg::LINE_WIDTH_W-1:0] w;
    logic                               restart;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w = '0;
        1:       w = 12'd1;
        2:       w = 12'd2;
        3:       w = 12'd3;
        8:       w = sobel_pkg::LINE_WIDTH_W'($urandom_range(17, 64));
        9:       w = sobel_pkg::LINE_WIDTH_W'($urandom_range(65, 160));
        default: w = sobel_pkg::LINE_WIDTH_W'($urandom_range(4, 16));
      endcase
      idle_enable = ($urandom_range(0, 3) != 0);
      write_line_width(w);
      w_eff   = (w == 0) ? 1 : w;
      n       = 2 * w_eff + 2 + $urandom_range(4, 40);
      restart = ($urandom_range(0, 4) != 0);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 249) == 0) begin
          hold_input();
          wait_results_done();
        end
        send_pixel(random_pixel(), (i == 0 && restart) || $urandom_range(0, 149) == 0);
      end
      sent += n;
      hold_input();
      wait_results_done();
    end
  endtask

  // Back-to-back transactions on both sides to close the run.
  task automatic test_quiet_tail();
    idle_enable = 1'b0;
    write_line_width(sobel_pkg::LINE_WIDTH_W'($urandom_range(2, 8)));
    for (int i = 0; i < TAIL_ITEMS; i++) send_pixel(random_pixel(), i == 0);
    hold_input();
  endtask

  // Main sequence.
  initial begin
    cfg_line_width = sobel_pkg::LINE_WIDTH_RST;
    clear_frame_state();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_access();
    test_directed_frames();
    test_width_change_midstream();
    test_pause_until_drained();
    test_widest_line();
    test_random_frames();
    test_quiet_tail();

    wait_results_done();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
